/* sv/cti_pkg.sv */
// cti_pkg: shared constants, types and helper functions for the cubic table interpolator
// no dependencies; used by the interfaces, the table memory and the top level
package cti_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int AW          = 10;
  localparam int LW          = 11;
  localparam int SB          = 16;
  localparam int FB          = 16;
  localparam int PW          = 32;
  localparam int HW          = 20;
  localparam int DW          = SB + 1;
  localparam int MW          = HW + DW + 1;
  localparam int ACW         = MW + 3;

  localparam logic REG_WRAP = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic          v;
    logic          smp;
    logic          last;
    logic          wrap;
    logic [AW-1:0] widx;
    logic [SB-1:0] wval;
  } cti_ctl_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [SB-1:0] wdata;
    logic [AW-1:0] a1;
    logic [AW-1:0] a2;
    logic [AW-1:0] a3;
    logic [AW-1:0] a4;
  } cti_mem_req_t;

  // four steps of restoring remainder, most significant bit first
  function automatic logic [LW-1:0] mod_step(input logic [LW-1:0] r, input logic [3:0] bits,
                                             input logic [LW-1:0] len);
    logic [LW:0]   t;
    logic [LW-1:0] acc;
    acc = r;
    for (int k = 3; k >= 0; k--) begin
      t = {acc, bits[k]};
      if (t >= {1'b0, len}) t = t - {1'b0, len};
      acc = t[LW-1:0];
    end
    return acc;
  endfunction

endpackage

/* sv/cti_if.sv */
// cti_if: valid/ready channel interfaces for table writes, sample requests and results
// depends on cti_pkg
interface cti_in_if
  import cti_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [AW-1:0]        entry_index;
  logic signed [SB-1:0] entry_value;
  logic signed [PW-1:0] position;
  logic                 batch_last;

  modport source(output valid, kind, entry_index, entry_value, position, batch_last,
                 input ready);
  modport sink(input valid, kind, entry_index, entry_value, position, batch_last,
               output ready);
endinterface

interface cti_out_if
  import cti_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic signed [SB-1:0] sample_value;
  logic                 batch_last_out;

  modport source(output valid, sample_value, batch_last_out, input ready);
  modport sink(input valid, sample_value, batch_last_out, output ready);
endinterface

/* sv/cubic_table_interpolator_top.sv */
// cubic_table_interpolator_top: catmull-rom interpolation over a loadable sample table
// depends on cti_pkg, cti_if and cti_table
//
// usage:
//   in_ch carries write transactions (kind 0: entry_index, entry_value) and sample
//   transactions (kind 1: q16.16 position, batch_last). out_ch returns one result per
//   sample transaction, in order; write transactions return nothing.
//   cfg_we/cfg_index/cfg_data set wrap_mode (index 0) and table_length (index 1)
//   while the block is idle.
// timing:
//   one transaction per cycle sustained unless a waiting result is stalled by out_ch.ready.
//   four pipeline stages reduce the position modulo the table length, then index
//   build, table read, weights, products and sum/saturate follow one stage each.
//   the table is four copies with one read port each, so all neighbours read at once.
// reset:
//   clears the pipeline valid bits, wrap_mode to 0 and table_length to 1024;
//   table contents are undefined until written.
// stall:
//   when out_ch.ready is low with a result waiting the whole pipeline holds and
//   in_ch.ready drops; nothing is lost or repeated.
module cubic_table_interpolator_top
  import cti_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cti_in_if.sink        in_ch,
  cti_out_if.source     out_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [LW-1:0] cfg_data
);

  logic          cfg_wrap;
  logic [LW-1:0] cfg_len;
  logic [LW-1:0] len_eff;
  logic [AW-1:0] maxi;
  logic          en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_wrap <= 1'b0;
      cfg_len  <= LW'(TABLE_DEPTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WRAP: cfg_wrap <= cfg_data[0];
        REG_LEN:  cfg_len  <= cfg_data;
        default:  cfg_wrap <= cfg_wrap;
      endcase
    end
  end

  always_comb begin
    if (cfg_len < LW'(2)) len_eff = LW'(2);
    else if (cfg_len > LW'(TABLE_DEPTH)) len_eff = LW'(TABLE_DEPTH);
    else len_eff = cfg_len;
    maxi = AW'(len_eff - LW'(1));
  end

  // stage a: position split, clamp, first remainder digit
  cti_ctl_t      a_ctl, b_ctl, c_ctl, d_ctl, e_ctl, f_ctl, g_ctl, h_ctl;
  logic [15:0]   a_mag, b_mag, c_mag;
  logic          a_neg, b_neg, c_neg, d_neg;
  logic [FB-1:0] a_w, b_w, c_w, d_w, e_w, f_w;
  logic [AW-1:0] a_cidx, b_cidx, c_cidx, d_cidx;
  logic [LW-1:0] a_rem, b_rem, c_rem, d_rem;

  logic [15:0]   in_ip;
  logic [15:0]   in_mag;
  logic [FB-1:0] in_w;
  logic [AW-1:0] in_cidx;
  logic [FB-1:0] in_cw;
  cti_ctl_t      in_ctl;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    in_ip  = in_ch.position[PW-1:FB];
    in_w   = in_ch.position[FB-1:0];
    in_mag = in_ch.position[PW-1] ? 16'(-in_ip) : in_ip;
    if (in_ch.position[PW-1]) begin
      in_cidx = '0;
      in_cw   = '0;
    end else if ({1'b0, in_ch.position[PW-2:FB]} > 16'(maxi) ||
                 ({1'b0, in_ch.position[PW-2:FB]} == 16'(maxi) && in_w != '0)) begin
      in_cidx = maxi;
      in_cw   = '0;
    end else begin
      in_cidx = in_ch.position[FB+AW-1:FB];
      in_cw   = in_w;
    end
    in_ctl.v    = in_ch.valid;
    in_ctl.smp  = (in_ch.kind == KIND_SAMPLE);
    in_ctl.last = in_ch.batch_last;
    in_ctl.wrap = cfg_wrap;
    in_ctl.widx = in_ch.entry_index;
    in_ctl.wval = in_ch.entry_value;
  end

  // stage e: neighbour indices and w squared
  logic [AW-1:0] e_i1, e_i2, e_i3, e_i4;
  logic [FB-1:0] e_w2;
  logic [AW-1:0] idx, n1, n3, n4;
  logic [LW-1:0] widx, t4;
  logic [2*FB-1:0] sq;

  always_comb begin
    widx = (d_neg && d_rem != '0) ? len_eff - d_rem : d_rem;
    idx  = d_ctl.wrap ? AW'(widx) : d_cidx;
    t4   = {1'b0, idx} + LW'(2);
    if (d_ctl.wrap) begin
      n1 = (idx > '0) ? idx - AW'(1) : maxi;
      n3 = (idx < maxi) ? idx + AW'(1) : '0;
      n4 = (t4 >= len_eff) ? AW'(t4 - len_eff) : AW'(t4);
    end else begin
      n1 = (idx > '0) ? idx - AW'(1) : '0;
      n3 = (idx < maxi) ? idx + AW'(1) : maxi;
      n4 = ({1'b0, idx} < {1'b0, maxi} - LW'(1)) ? AW'(t4) : maxi;
    end
    sq = d_w * d_w + (2*FB)'(1 << (FB - 1));
  end

  // stage f: table read, w cubed
  cti_mem_req_t          mreq;
  logic signed [SB-1:0]  f_p1, f_p2, f_p3, f_p4;
  logic [FB-1:0]         f_w2, f_w3;
  logic [2*FB-1:0]       cu;

  always_comb begin
    mreq.we    = e_ctl.v && !e_ctl.smp;
    mreq.waddr = e_ctl.widx;
    mreq.wdata = e_ctl.wval;
    mreq.a1    = e_i1;
    mreq.a2    = e_i2;
    mreq.a3    = e_i3;
    mreq.a4    = e_i4;
    cu         = e_w2 * e_w + (2*FB)'(1 << (FB - 1));
  end

  cti_table u_table (
    .clk (clk),
    .en  (en),
    .req (mreq),
    .p1  (f_p1),
    .p2  (f_p2),
    .p3  (f_p3),
    .p4  (f_p4)
  );

  // stage g: weights and differences
  logic signed [HW-1:0] g_h1, g_h2, g_h3, g_h4;
  logic signed [HW-1:0] w_s, w2_s, w3_s, h1_n, h2_n, h3_n, h4_n;
  logic signed [DW-1:0] g_d31, g_d42, g_p2, g_p3;

  always_comb begin
    w_s  = $signed(HW'(f_w));
    w2_s = $signed(HW'(f_w2));
    w3_s = $signed(HW'(f_w3));
    h2_n = (w2_s <<< 1) + w2_s - (w3_s <<< 1);
    h1_n = $signed(HW'(1 << FB)) - h2_n;
    h4_n = w3_s - w2_s;
    h3_n = h4_n - w2_s + w_s;
  end

  // stage h: products
  logic signed [MW-1:0] h_m1, h_m2, h_m3, h_m4;

  // stage j: sum, round, saturate
  logic signed [ACW-1:0] acc;
  logic signed [ACW-1:0] res;
  logic signed [SB-1:0]  sat;
  logic                  j_last;
  logic signed [SB-1:0]  j_val;
  logic                  j_v;

  always_comb begin
    acc = ((ACW'(h_m1) + ACW'(h_m2)) <<< 1) + ACW'(h_m3) + ACW'(h_m4)
          + $signed(ACW'(1 << FB));
    res = acc >>> (FB + 1);
    if (res > $signed(ACW'((1 << (SB - 1)) - 1)))  sat = SB'((1 << (SB - 1)) - 1);
    else if (res < -$signed(ACW'(1 << (SB - 1))))  sat = SB'(1 << (SB - 1));
    else sat = SB'(res);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl.v <= 1'b0;
      b_ctl.v <= 1'b0;
      c_ctl.v <= 1'b0;
      d_ctl.v <= 1'b0;
      e_ctl.v <= 1'b0;
      f_ctl.v <= 1'b0;
      g_ctl.v <= 1'b0;
      h_ctl.v <= 1'b0;
      j_v     <= 1'b0;
    end else if (en) begin
      a_ctl.v <= in_ctl.v;
      b_ctl.v <= a_ctl.v;
      c_ctl.v <= b_ctl.v;
      d_ctl.v <= c_ctl.v;
      e_ctl.v <= d_ctl.v;
      f_ctl.v <= e_ctl.v;
      g_ctl.v <= f_ctl.v;
      h_ctl.v <= g_ctl.v;
      j_v     <= h_ctl.v && h_ctl.smp;
    end

    if (en) begin
      {a_ctl.smp, a_ctl.last, a_ctl.wrap, a_ctl.widx, a_ctl.wval} <=
        {in_ctl.smp, in_ctl.last, in_ctl.wrap, in_ctl.widx, in_ctl.wval};
      {b_ctl.smp, b_ctl.last, b_ctl.wrap, b_ctl.widx, b_ctl.wval} <=
        {a_ctl.smp, a_ctl.last, a_ctl.wrap, a_ctl.widx, a_ctl.wval};
      {c_ctl.smp, c_ctl.last, c_ctl.wrap, c_ctl.widx, c_ctl.wval} <=
        {b_ctl.smp, b_ctl.last, b_ctl.wrap, b_ctl.widx, b_ctl.wval};
      {d_ctl.smp, d_ctl.last, d_ctl.wrap, d_ctl.widx, d_ctl.wval} <=
        {c_ctl.smp, c_ctl.last, c_ctl.wrap, c_ctl.widx, c_ctl.wval};
      {e_ctl.smp, e_ctl.last, e_ctl.wrap, e_ctl.widx, e_ctl.wval} <=
        {d_ctl.smp, d_ctl.last, d_ctl.wrap, d_ctl.widx, d_ctl.wval};
      {f_ctl.smp, f_ctl.last, f_ctl.wrap, f_ctl.widx, f_ctl.wval} <=
        {e_ctl.smp, e_ctl.last, e_ctl.wrap, e_ctl.widx, e_ctl.wval};
      {g_ctl.smp, g_ctl.last, g_ctl.wrap, g_ctl.widx, g_ctl.wval} <=
        {f_ctl.smp, f_ctl.last, f_ctl.wrap, f_ctl.widx, f_ctl.wval};
      {h_ctl.smp, h_ctl.last, h_ctl.wrap, h_ctl.widx, h_ctl.wval} <=
        {g_ctl.smp, g_ctl.last, g_ctl.wrap, g_ctl.widx, g_ctl.wval};

      a_mag  <= in_mag;
      a_neg  <= in_ch.position[PW-1];
      a_w    <= cfg_wrap ? in_w : in_cw;
      a_cidx <= in_cidx;
      a_rem  <= mod_step('0, in_mag[15:12], len_eff);

      b_mag  <= a_mag;
      b_neg  <= a_neg;
      b_w    <= a_w;
      b_cidx <= a_cidx;
      b_rem  <= mod_step(a_rem, a_mag[11:8], len_eff);

      c_mag  <= b_mag;
      c_neg  <= b_neg;
      c_w    <= b_w;
      c_cidx <= b_cidx;
      c_rem  <= mod_step(b_rem, b_mag[7:4], len_eff);

      d_neg  <= c_neg;
      d_w    <= c_w;
      d_cidx <= c_cidx;
      d_rem  <= mod_step(c_rem, c_mag[3:0], len_eff);

      e_i1 <= n1;
      e_i2 <= idx;
      e_i3 <= n3;
      e_i4 <= n4;
      e_w  <= d_w;
      e_w2 <= sq[2*FB-1:FB];

      f_w  <= e_w;
      f_w2 <= e_w2;
      f_w3 <= cu[2*FB-1:FB];

      g_h1  <= h1_n;
      g_h2  <= h2_n;
      g_h3  <= h3_n;
      g_h4  <= h4_n;
      g_p2  <= DW'(f_p2);
      g_p3  <= DW'(f_p3);
      g_d31 <= DW'(f_p3) - DW'(f_p1);
      g_d42 <= DW'(f_p4) - DW'(f_p2);

      h_m1 <= MW'(g_h1) * MW'(g_p2);
      h_m2 <= MW'(g_h2) * MW'(g_p3);
      h_m3 <= MW'(g_h3) * MW'(g_d31);
      h_m4 <= MW'(g_h4) * MW'(g_d42);

      j_val  <= sat;
      j_last <= h_ctl.last;
    end
  end

  assign out_ch.valid          = j_v;
  assign out_ch.sample_value   = j_val;
  assign out_ch.batch_last_out = j_last;

`ifndef SYNTH
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    d_ctl.v && d_ctl.smp && d_ctl.wrap |-> d_rem < len_eff)
    else $error("remainder not below table length");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    e_ctl.v && e_ctl.smp |-> {1'b0, e_i1} < len_eff && {1'b0, e_i2} < len_eff &&
                             {1'b0, e_i3} < len_eff && {1'b0, e_i4} < len_eff)
    else $error("neighbour index outside table");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.sample_value))
    else $error("stalled result lost");
`endif

endmodule

/* sv/cti_table.sv */
// cti_table: sample table held as four copies, one read port each, registered reads
// depends on cti_pkg
module cti_table
  import cti_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  cti_mem_req_t         req,
  output logic signed [SB-1:0] p1,
  output logic signed [SB-1:0] p2,
  output logic signed [SB-1:0] p3,
  output logic signed [SB-1:0] p4
);

  logic [SB-1:0] mem1 [TABLE_DEPTH];
  logic [SB-1:0] mem2 [TABLE_DEPTH];
  logic [SB-1:0] mem3 [TABLE_DEPTH];
  logic [SB-1:0] mem4 [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (req.we) begin
        mem1[req.waddr] <= req.wdata;
        mem2[req.waddr] <= req.wdata;
        mem3[req.waddr] <= req.wdata;
        mem4[req.waddr] <= req.wdata;
      end
      p1 <= mem1[req.a1];
      p2 <= mem2[req.a2];
      p3 <= mem3[req.a3];
      p4 <= mem4[req.a4];
    end
  end

endmodule

/* tb/sv/cti_checker.sv */
// cti_checker: watches the request and result channels of the cubic table interpolator,
// predicts each interpolated sample and compares it; depends on cti_pkg and cti_if
module cti_checker
  import cti_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  cti_in_if.sink        in_mon,
  cti_out_if.sink       out_mon,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [LW-1:0] cfg_data,
  output int            fail_count,
  output int            pending
);

  typedef struct {
    logic signed [SB-1:0] value;
    logic                 last;
  } sample_t;

  logic signed [SB-1:0] samples [TABLE_DEPTH];
  logic                 wrap_q;
  logic [LW-1:0]        len_q;
  sample_t              expected_samples[$];

  assign pending = expected_samples.size();

  function automatic longint floor_div_pow2(longint x, int s);
    return x >>> s;
  endfunction

  function automatic sample_t interpolate(logic signed [PW-1:0] pos_in, logic last);
    sample_t r;
    longint one, len, maxi, pos, idx, ip, w, w2, w3, h1, h2, h3, h4, acc, res;
    longint i1, i3, i4, p1, p2, p3, p4;
    one = 64'sd1 << FB;
    len = len_q;
    if (len < 2) len = 2;
    if (len > TABLE_DEPTH) len = TABLE_DEPTH;
    maxi = len - 1;
    pos = pos_in;
    if (wrap_q) begin
      ip = floor_div_pow2(pos, FB);
      w = pos & (one - 1);
      idx = ip % len;
      if (idx < 0) idx += len;
      i1 = idx > 0 ? idx - 1 : maxi;
      i3 = idx < maxi ? idx + 1 : 0;
      i4 = (idx + 2) % len;
    end else begin
      if (pos < 0) pos = 0;
      if (pos > maxi * one) pos = maxi * one;
      idx = pos >>> FB;
      w = pos & (one - 1);
      i1 = idx > 0 ? idx - 1 : 0;
      i3 = idx < maxi ? idx + 1 : maxi;
      i4 = idx < maxi - 1 ? idx + 2 : maxi;
    end
    p1 = samples[i1];
    p2 = samples[idx];
    p3 = samples[i3];
    p4 = samples[i4];
    w2 = (w * w + (one >>> 1)) >>> FB;
    w3 = (w2 * w + (one >>> 1)) >>> FB;
    h2 = 3 * w2 - 2 * w3;
    h1 = one - h2;
    h4 = w3 - w2;
    h3 = h4 - w2 + w;
    acc = 2 * (h1 * p2 + h2 * p3) + h3 * (p3 - p1) + h4 * (p4 - p2);
    res = floor_div_pow2(acc + one, FB + 1);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    r.value = res[SB-1:0];
    r.last = last;
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t e;
    int      errs;
    if (rst) begin
      wrap_q <= 1'b0;
      len_q <= 11'd1024;
      fail_count <= 0;
      expected_samples.delete();
    end else begin
      errs = 0;
      if (cfg_we) begin
        if (cfg_index == REG_WRAP) wrap_q <= cfg_data[0];
        else len_q <= cfg_data;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_WRITE) samples[in_mon.entry_index] = in_mon.entry_value;
        else expected_samples.push_back(interpolate(in_mon.position, in_mon.batch_last));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected transaction: sample_value %0d", out_mon.sample_value);
          errs++;
        end else begin
          e = expected_samples.pop_front();
          if (out_mon.sample_value !== e.value) begin
            $error("sample_value expected %0d actual %0d", e.value, out_mon.sample_value);
            errs++;
          end
          if (out_mon.batch_last_out !== e.last) begin
            $error("batch_last_out expected %0b actual %0b", e.last, out_mon.batch_last_out);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* tb/sv/cubic_table_interpolator_top_test.sv */
// cubic_table_interpolator_top_test: drives table writes, sample requests and register
// settings into the interpolator; depends on cti_pkg, cti_if, the block and cti_checker
module cubic_table_interpolator_top_test;
  import cti_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LATENCY = 9;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_index = REG_WRAP;
  logic [LW-1:0] cfg_data = '0;
  int            fail_count;
  int            pending;
  int            cycle_count = 0;
  bit            sink_idle_ok = 1'b1;
  bit            long_hold = 1'b0;
  int            cur_len = 1024;

  cti_in_if  in_ch();
  cti_out_if out_ch();

  cubic_table_interpolator_top u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cti_checker u_checker (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_value = '0;
    in_ch.position = '0;
    in_ch.batch_last = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stall bursts, a long hold-off on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
      end else if (sink_idle_ok && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send(logic k, logic [AW-1:0] ei, logic [SB-1:0] ev, logic [PW-1:0] pos,
                      logic last, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.entry_index <= ei;
    in_ch.entry_value <= ev;
    in_ch.position <= pos;
    in_ch.batch_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_entry(int i, logic [SB-1:0] v, bit gaps);
    send(KIND_WRITE, i[AW-1:0], v, $urandom, 1'($urandom_range(0, 1)), gaps);
  endtask

  task automatic request(logic [PW-1:0] pos, bit gaps);
    send(KIND_SAMPLE, AW'($urandom), SB'($urandom), pos, 1'($urandom_range(0, 1)), gaps);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_reg(logic idx, logic [LW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [PW-1:0] rand_pos(int mode);
    case (mode)
      0: return $urandom;
      1: return {16'($urandom_range(0, cur_len + 2)), 16'($urandom)};
      default: return -{16'($urandom_range(0, 3 * cur_len)), 16'($urandom)};
    endcase
  endfunction

  initial begin
    int lens [4];
    lens = '{64, 2, 3, 37};
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // fill every entry that a sample can reach
    for (int i = 0; i < 64; i++) write_entry(i, SB'($urandom), 1'b0);
    for (int i = TABLE_DEPTH - 4; i < TABLE_DEPTH; i++) write_entry(i, SB'($urandom), 1'b0);
    drain();
    // directed: extremes of value and position in both modes
    write_entry(0, 16'h7fff, 1'b0);
    write_entry(1, 16'h8000, 1'b0);
    write_entry(2, 16'h7fff, 1'b0);
    write_entry(3, 16'h8000, 1'b0);
    write_entry(1023, 16'h7fff, 1'b0);
    request(32'h0000_0000, 1'b0);
    request(32'h0000_8000, 1'b0);
    request(32'h0001_ffff, 1'b0);
    request(32'h7fff_ffff, 1'b0);
    request(32'h8000_0000, 1'b0);
    request(32'h03ff_4000, 1'b0);
    request(32'hffff_ffff, 1'b0);
    drain();
    set_reg(REG_WRAP, 11'd1);
    request(32'h7fff_ffff, 1'b0);
    request(32'h8000_0000, 1'b0);
    request(32'hffff_8000, 1'b0);
    request(32'h03ff_c000, 1'b0);
    request(32'h0400_0001, 1'b0);
    drain();
    set_reg(REG_LEN, 11'd0);
    request(32'h0001_8000, 1'b0);
    request(32'hfffe_2000, 1'b0);
    drain();
    set_reg(REG_LEN, 11'h7ff);
    request(32'h03ff_8000, 1'b0);
    drain();
    // random phases across both modes and several lengths
    for (int ph = 0; ph < 8; ph++) begin
      cur_len = lens[ph % 4];
      set_reg(REG_WRAP, LW'(ph[0]));
      set_reg(REG_LEN, cur_len[LW-1:0]);
      if (ph == 2) long_hold = 1'b1;
      if (ph == 7) sink_idle_ok = 1'b0;
      for (int k = 0; k < 46; k++) begin
        if ($urandom_range(0, 4) == 0)
          write_entry($urandom_range(0, TABLE_DEPTH - 1), SB'($urandom), ph != 7);
        else
          request(rand_pos($urandom_range(0, 2)), ph != 7);
      end
      drain();
    end
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
